[rtl/positional_list_engine_top_defines.svh]
// Assertion macros for the positional list engine.
// Used by positional_list_engine_top; depends on its clk and arst_n ports.
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PLE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that, once seen, must be followed in the next cycle by another.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// An implication within the same cycle.
`define PLE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/ple_pkg.sv]
// Shared types and codes of the positional list engine.
// No dependencies; used by ple_cell and positional_list_engine_top.
package ple_pkg;

	// Operation codes carried on func.
	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_DELETE = 2'd1;
	localparam logic [1:0] FN_READ   = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned TOTAL_W = 5;

	// Per-cell load and select controls from the top level.
	typedef struct packed {
		logic ld_left;   // take the lower neighbor's value (insert shift)
		logic ld_new;    // take the inserted value
		logic ld_right;  // take the upper neighbor's value (delete shift)
		logic sel;       // this cell is the addressed position
	} cell_ctl_t;

endpackage

[rtl/ple_cell.sv]
// One storage cell of the positional list engine's chain.
// Depends on ple_pkg for cell_ctl_t and DATA_W.
module ple_cell (
	input  logic                          clk,
	input  ple_pkg::cell_ctl_t            ctl,
	input  logic [ple_pkg::DATA_W-1:0]    left,
	input  logic [ple_pkg::DATA_W-1:0]    right,
	input  logic [ple_pkg::DATA_W-1:0]    value,
	output logic [ple_pkg::DATA_W-1:0]    data_q,
	output logic [ple_pkg::DATA_W-1:0]    hit_data
);

	// Contents are undefined until written, so the cell has no reset.
	// In most cycles no load is requested and the cell simply holds.
	always_ff @(posedge clk) begin
		if (ctl.ld_left) begin
			data_q <= left;
		end else if (ctl.ld_new) begin
			data_q <= value;
		end else if (ctl.ld_right) begin
			data_q <= right;
		end
	end

	// Only the addressed cell drives the read bus; the rest contribute zero.
	assign hit_data = ctl.sel ? data_q : '0;

endmodule

[rtl/positional_list_engine_top.sv]
// Top level of the positional list engine: a chain of ple_cell storage cells
// plus count, checking and result logic. Depends on ple_pkg, ple_cell and
// positional_list_engine_top_defines.svh.

// The engine holds an ordered list of up to DEPTH signed 32-bit entries in a
// row of cells and takes one command word per clock cycle: busy stays low, so
// a word is accepted at every rising edge with start high. Each command
// (insert, delete or read at a one-based position) produces exactly one
// result word, shown on status, read_value and entry_total with done high
// for exactly one cycle, the cycle right after the command was accepted.
// Results cannot be stalled; the receiver must take each one as it comes.
// The result registers sit right behind the cells: every cell loads from
// its lower neighbor, its upper neighbor or the command value in the same
// edge, and the read path is a wide OR of the one selected cell.
`include "positional_list_engine_top_defines.svh"

module positional_list_engine_top #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    func,
	input  logic [ple_pkg::POS_W-1:0]     position,
	input  logic signed [ple_pkg::DATA_W-1:0] value,
	output logic                          done,
	output logic [1:0]                    status,
	output logic signed [ple_pkg::DATA_W-1:0] read_value,
	output logic [ple_pkg::TOTAL_W-1:0]   entry_total
);

	// The count must hold DEPTH itself.
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	// Comparison width wide enough for the count, the position and count+1.
	localparam int unsigned CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;

	logic                     accept;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_next;
	logic [CMP_W-1:0]         pos_w;
	logic [CMP_W-1:0]         cnt_w;
	logic [CMP_W-1:0]         pos_idx;
	logic                     pos_nonzero;
	logic                     is_full;
	logic                     do_ins;
	logic                     do_del;
	logic                     do_rd;
	logic [1:0]               status_d;
	logic [ple_pkg::DATA_W-1:0] read_d;

	ple_pkg::cell_ctl_t       cell_ctl [DEPTH];
	logic [ple_pkg::DATA_W-1:0] cell_q   [DEPTH];
	logic [ple_pkg::DATA_W-1:0] cell_hit [DEPTH];
	logic [ple_pkg::DATA_W-1:0] hit_or   [DEPTH+1];

	// A command word is taken every cycle that start is high.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign pos_w       = CMP_W'(position);
	assign cnt_w       = CMP_W'(count_q);
	assign pos_idx     = pos_w - CMP_W'(1);
	assign pos_nonzero = (position != '0);
	assign is_full     = (count_q == CNT_W'(DEPTH));

	// Decode and validate the command. The position is checked before the
	// full condition, so a bad position on a full list reports a bad position.
	always_comb begin
		do_ins   = 1'b0;
		do_del   = 1'b0;
		do_rd    = 1'b0;
		status_d = ple_pkg::ST_BADPOS;
		unique case (func)
			ple_pkg::FN_INSERT: begin
				if (pos_nonzero && (pos_w <= cnt_w + CMP_W'(1))) begin
					if (is_full) begin
						status_d = ple_pkg::ST_FULL;
					end else begin
						status_d = ple_pkg::ST_DONE;
						do_ins   = accept;
					end
				end
			end
			ple_pkg::FN_DELETE: begin
				if (pos_nonzero && (pos_w <= cnt_w)) begin
					status_d = ple_pkg::ST_DONE;
					do_del   = accept;
				end
			end
			ple_pkg::FN_READ: begin
				if (pos_nonzero && (pos_w <= cnt_w)) begin
					status_d = ple_pkg::ST_DONE;
					do_rd    = accept;
				end
			end
			default: begin
				// The unused code changes nothing and reports a bad position.
				status_d = ple_pkg::ST_BADPOS;
			end
		endcase
	end

	always_comb begin
		priority if (do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_del) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	// The cell chain. Cells above the insert point take their lower
	// neighbor, the insert point takes the new value; on a delete the
	// removed cell and all above it take their upper neighbor. Cells past
	// the count may pick up stale data; they are never read.
	assign hit_or[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CMP_W-1:0] IDX = CMP_W'(i);

		logic [ple_pkg::DATA_W-1:0] left_data;
		logic [ple_pkg::DATA_W-1:0] right_data;

		assign cell_ctl[i].ld_left  = do_ins && (IDX > pos_idx);
		assign cell_ctl[i].ld_new   = do_ins && (IDX == pos_idx);
		assign cell_ctl[i].ld_right = do_del && (IDX >= pos_idx);
		assign cell_ctl[i].sel      = IDX == pos_idx;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_mid_left
			assign left_data = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_mid_right
			assign right_data = cell_q[i+1];
		end

		ple_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[i]),
			.left     (left_data),
			.right    (right_data),
			.value    (value),
			.data_q   (cell_q[i]),
			.hit_data (cell_hit[i])
		);

		assign hit_or[i+1] = hit_or[i] | cell_hit[i];
	end

	// Read data is the addressed cell for a read or the removed cell for a
	// delete, and zero for everything else.
	assign read_d = (do_rd || do_del) ? hit_or[DEPTH] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			count_q <= count_next;
			done    <= accept;
		end
	end

	// Result word registers; meaningful only while done is high.
	always_ff @(posedge clk) begin
		if (accept) begin
			status      <= status_d;
			read_value  <= read_d;
			entry_total <= ple_pkg::TOTAL_W'(count_next);
		end
	end

	// Every accepted command yields its result in the following cycle.
	`PLE_ASSERT_NEXT(a_result_follows, accept, done, "accepted command produced no result word")
	// The count never grows past the number of cells.
	`PLE_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count exceeds DEPTH")
	// A rejected command leaves the count as it was.
	`PLE_ASSERT_SAME(a_reject_keeps, done && (status != ple_pkg::ST_DONE), count_q == $past(count_q), "rejected command changed the count")
	// A full-list rejection only happens on a full list.
	`PLE_ASSERT_SAME(a_full_status, done && (status == ple_pkg::ST_FULL), count_q == CNT_W'(DEPTH), "list-full status with free cells")

endmodule
